FILE: design/cffp_pkg.sv
`timescale 1ns / 1ps

package cffp_pkg;

    localparam int SIZE_W   = 7;
    localparam int TAG_W    = 16;
    localparam int ID_W     = 16;
    localparam int CREDIT_W = 7;
    localparam int SEQ_W    = 6;

    // Credit counter limits
    localparam logic [CREDIT_W-1:0] CREDIT_RESET   = 7'd4;
    localparam logic [CREDIT_W-1:0] CREDIT_CEILING = 7'd64;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_PACKET = 2'd1,
        MODE_CREDIT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_HEAD   = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_TAIL   = 2'd2,
        KIND_SINGLE = 2'd3
    } flit_kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
        logic   pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic   full;
        logic   nonempty;
        entry_t head;
    } queue_stat_t;

    typedef struct packed {
        logic                load;
        logic [CREDIT_W-1:0] load_value;
        logic                ret;
        logic [ID_W-1:0]     ret_id;
        logic                take;
    } credit_ctrl_t;

endpackage

FILE: design/cffp_ram.sv
`timescale 1ns / 1ps

module cffp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/cffp_queue.sv
`timescale 1ns / 1ps

module cffp_queue #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cffp_pkg::queue_ctrl_t ctrl,
    output cffp_pkg::queue_stat_t stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(cffp_pkg::entry_t);

    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              byp_hit_reg, byp_hit_next;
    cffp_pkg::entry_t  byp_data_reg;
    logic [EW-1:0]     rd_data;
    logic              full;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full = (count_reg == CW'(DEPTH));

    always_comb
    begin
        head_next  = ctrl.pop  ? wrap_inc(head_reg) : head_reg;
        tail_next  = ctrl.push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        // a write landing on the slot about to be read must be forwarded
        byp_hit_next = ctrl.push && (tail_reg == head_next);
    end

    // read address follows the next head so the registered read data matches head_reg
    cffp_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctrl.push),
        .wr_addr (tail_reg),
        .wr_data (ctrl.entry),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            byp_hit_reg <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byp_hit_next)
        begin
            byp_data_reg <= ctrl.entry;
        end
    end

    always_comb
    begin
        stat.full     = full;
        stat.nonempty = (count_reg != '0);
        stat.head     = byp_hit_reg ? byp_data_reg : cffp_pkg::entry_t'(rd_data);
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(ctrl.push && full))
        else $error("push into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) ctrl.pop |-> (count_reg != '0))
        else $error("pop from an empty queue");

endmodule

FILE: design/cffp_credit.sv
`timescale 1ns / 1ps

module cffp_credit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cffp_pkg::credit_ctrl_t             ctrl,
    output logic [cffp_pkg::CREDIT_W-1:0]      count,
    output logic [cffp_pkg::CREDIT_W-1:0]      count_next
);

    logic [cffp_pkg::CREDIT_W-1:0] count_reg;
    logic                          last_valid_reg, last_valid_next;
    logic [cffp_pkg::ID_W-1:0]     last_id_reg, last_id_next;
    logic                          fresh;

    always_comb
    begin
        fresh           = !last_valid_reg || (last_id_reg != ctrl.ret_id);
        count_next      = count_reg;
        last_valid_next = last_valid_reg;
        last_id_next    = last_id_reg;
        priority if (ctrl.load)
        begin
            count_next = ctrl.load_value;
        end
        else if (ctrl.ret)
        begin
            // drop repeats and any credit with the counter at the ceiling, record the id anyway
            if (fresh && (count_reg < cffp_pkg::CREDIT_CEILING))
            begin
                count_next = count_reg + 7'd1;
            end
            last_valid_next = 1'b1;
            last_id_next    = ctrl.ret_id;
        end
        else if (ctrl.take)
        begin
            count_next = count_reg - 7'd1;
        end
        else
        begin
            // hold the counter and the last id
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= cffp_pkg::CREDIT_RESET;
            last_valid_reg <= 1'b0;
            last_id_reg    <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            last_valid_reg <= last_valid_next;
            last_id_reg    <= last_id_next;
        end
    end

    assign count = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n) ctrl.take |-> (count_reg != '0))
        else $error("credit taken with counter at zero");

endmodule

FILE: design/credit_flow_flit_packetizer_unit.sv
`timescale 1ns / 1ps
// Data path: an accepted input word passes through the input register, then the result
//   register; one result word per input word.
// Throughput: one word per cycle unless out_stall holds the result stage; the queue
//   head is read from a registered-read RAM addressed by the next head pointer, forwarding a same-slot write.
// Reset: queue empty, flit index zero, credit counter 4, no credit id seen.
//   The queue RAM is not cleared; only written slots are ever read.

module credit_flow_flit_packetizer_unit #(
    parameter int QUEUE_DEPTH      = 16,
    parameter int MAX_PACKET_FLITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic [cffp_pkg::SIZE_W-1:0]       packet_size,
    input  logic [cffp_pkg::TAG_W-1:0]        packet_tag,
    input  logic [cffp_pkg::ID_W-1:0]         credit_id,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              flit_valid,
    output logic [1:0]                        flit_kind,
    output logic [cffp_pkg::SEQ_W-1:0]        flit_seq,
    output logic [cffp_pkg::TAG_W-1:0]        flit_tag,
    output logic                              packet_dropped,
    output logic [cffp_pkg::CREDIT_W-1:0]     credits_left,
    // configuration: credit_init
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cffp_pkg::CREDIT_W-1:0]     credit_init
);

    // Largest packet the size field can actually express after saturation
    localparam int SatFlits = (MAX_PACKET_FLITS < 127) ? MAX_PACKET_FLITS : 127;
    localparam logic [cffp_pkg::SIZE_W-1:0] SAT_SIZE = cffp_pkg::SIZE_W'(SatFlits);

    // Input register stage
    logic                          in_valid_reg;
    cffp_pkg::mode_t               mode_reg;
    logic [cffp_pkg::SIZE_W-1:0]   size_reg;
    logic [cffp_pkg::TAG_W-1:0]    tag_reg;
    logic [cffp_pkg::ID_W-1:0]     id_reg;

    // Result register stage
    logic                          out_valid_reg;
    logic                          flit_valid_reg, flit_valid_next;
    cffp_pkg::flit_kind_t          flit_kind_reg, flit_kind_next;
    logic [cffp_pkg::SEQ_W-1:0]    flit_seq_reg, flit_seq_next;
    logic [cffp_pkg::TAG_W-1:0]    flit_tag_reg, flit_tag_next;
    logic                          dropped_reg, dropped_next;
    logic [cffp_pkg::CREDIT_W-1:0] credits_reg;

    // Flit position within the head packet
    logic [cffp_pkg::SIZE_W-1:0]   flit_index_reg, flit_index_next;
    logic [cffp_pkg::SIZE_W:0]     idx_inc;
    logic                          last_flit;

    logic                          advance;
    logic                          work;
    logic [cffp_pkg::SIZE_W-1:0]   size_fixed;

    cffp_pkg::queue_ctrl_t         q_ctrl;
    cffp_pkg::queue_stat_t         q_stat;
    cffp_pkg::credit_ctrl_t        c_ctrl;
    logic [cffp_pkg::CREDIT_W-1:0] credit_count;
    logic [cffp_pkg::CREDIT_W-1:0] credit_count_next;

    // Advance the result stage when it is empty or being drained; stall the
    // input only while a word waits in the input register and cannot move on.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign work     = in_valid_reg && advance;

    // Take configuration only with no word in the input register
    assign cfg_ready = !in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= cffp_pkg::mode_t'(mode);
            size_reg <= packet_size;
            tag_reg  <= packet_tag;
            id_reg   <= credit_id;
        end
    end

    // Clamp size: zero becomes a single flit, oversize saturates
    always_comb
    begin
        priority if (size_reg == '0)
        begin
            size_fixed = cffp_pkg::SIZE_W'(1);
        end
        else if (size_reg > SAT_SIZE)
        begin
            size_fixed = SAT_SIZE;
        end
        else
        begin
            size_fixed = size_reg;
        end
    end

    assign idx_inc   = {1'b0, flit_index_reg} + (cffp_pkg::SIZE_W + 1)'(1);
    assign last_flit = idx_inc >= {1'b0, q_stat.head.size};

    // Decode the word held in the input register against the current state
    always_comb
    begin
        q_ctrl.push       = 1'b0;
        q_ctrl.entry.size = size_fixed;
        q_ctrl.entry.tag  = tag_reg;
        q_ctrl.pop        = 1'b0;

        c_ctrl.load       = cfg_valid && cfg_ready;
        c_ctrl.load_value = credit_init;
        c_ctrl.ret        = 1'b0;
        c_ctrl.ret_id     = id_reg;
        c_ctrl.take       = 1'b0;

        flit_index_next   = flit_index_reg;
        flit_valid_next   = 1'b0;
        flit_kind_next    = cffp_pkg::KIND_HEAD;
        flit_seq_next     = '0;
        flit_tag_next     = '0;
        dropped_next      = 1'b0;

        if (work)
        begin
            unique case (mode_reg)
                cffp_pkg::MODE_PACKET:
                begin
                    if (q_stat.full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        q_ctrl.push = 1'b1;
                    end
                end
                cffp_pkg::MODE_CREDIT:
                begin
                    c_ctrl.ret = 1'b1;
                end
                cffp_pkg::MODE_TICK:
                begin
                    // Send one flit of the head packet if a credit remains
                    if (q_stat.nonempty && (credit_count != '0))
                    begin
                        c_ctrl.take     = 1'b1;
                        flit_valid_next = 1'b1;
                        flit_seq_next   = flit_index_reg[cffp_pkg::SEQ_W-1:0];
                        flit_tag_next   = q_stat.head.tag;
                        priority if (q_stat.head.size == cffp_pkg::SIZE_W'(1))
                        begin
                            flit_kind_next = cffp_pkg::KIND_SINGLE;
                        end
                        else if (flit_index_reg == '0)
                        begin
                            flit_kind_next = cffp_pkg::KIND_HEAD;
                        end
                        else if (last_flit)
                        begin
                            flit_kind_next = cffp_pkg::KIND_TAIL;
                        end
                        else
                        begin
                            flit_kind_next = cffp_pkg::KIND_BODY;
                        end
                        // Retire the packet after its last flit
                        if (last_flit)
                        begin
                            flit_index_next = '0;
                            q_ctrl.pop      = 1'b1;
                        end
                        else
                        begin
                            flit_index_next = idx_inc[cffp_pkg::SIZE_W-1:0];
                        end
                    end
                end
                default:
                begin
                    // unused mode: no state change, empty result
                end
            endcase
        end
    end

    cffp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    cffp_credit u_credit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (c_ctrl),
        .count      (credit_count),
        .count_next (credit_count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flit_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            flit_index_reg <= flit_index_next;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Result payload: load only when a word moves into the result stage
    always_ff @(posedge clk)
    begin
        if (work)
        begin
            flit_valid_reg <= flit_valid_next;
            flit_kind_reg  <= flit_kind_next;
            flit_seq_reg   <= flit_seq_next;
            flit_tag_reg   <= flit_tag_next;
            dropped_reg    <= dropped_next;
            credits_reg    <= credit_count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign flit_valid     = flit_valid_reg;
    assign flit_kind      = flit_kind_reg;
    assign flit_seq       = flit_seq_reg;
    assign flit_tag       = flit_tag_reg;
    assign packet_dropped = dropped_reg;
    assign credits_left   = credits_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !flit_valid) |->
            (flit_kind == cffp_pkg::KIND_HEAD) && (flit_seq == '0) && (flit_tag == '0))
        else $error("idle result carries flit fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && flit_valid) |-> !packet_dropped)
        else $error("flit and drop flagged on one result");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int QDEPTH    = 16;
    localparam int MAX_FLITS = 64;
    localparam int N_PHASES  = 8;
    localparam int PHASE_LEN = 85;

    // mode three has no member in the package enum; the block must ignore it
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum int {ROW_WORD, ROW_CHECKED, ROW_CFG} row_kind_t;

    typedef struct {
        logic [1:0]                  mode;
        logic [cffp_pkg::SIZE_W-1:0] size;
        logic [cffp_pkg::TAG_W-1:0]  tag;
        logic [cffp_pkg::ID_W-1:0]   id;
    } in_word_t;

    typedef struct {
        logic                          fv;
        logic [1:0]                    kind;
        logic [cffp_pkg::SEQ_W-1:0]    seq;
        logic [cffp_pkg::TAG_W-1:0]    tag;
        logic                          dropped;
        logic [cffp_pkg::CREDIT_W-1:0] credits;
    } flit_res_t;

    typedef struct {
        row_kind_t kind;
        in_word_t  w;
        flit_res_t want;
    } dir_row_t;

    // clock, reset and block inputs, all known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] mode = cffp_pkg::MODE_TICK;
    logic [cffp_pkg::SIZE_W-1:0] packet_size = '0;
    logic [cffp_pkg::TAG_W-1:0] packet_tag = '0;
    logic [cffp_pkg::ID_W-1:0] credit_id = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [cffp_pkg::CREDIT_W-1:0] credit_init = cffp_pkg::CREDIT_RESET;

    logic                          in_stall;
    logic                          out_valid;
    logic                          flit_valid;
    logic [1:0]                    flit_kind;
    logic [cffp_pkg::SEQ_W-1:0]    flit_seq;
    logic [cffp_pkg::TAG_W-1:0]    flit_tag;
    logic                          packet_dropped;
    logic [cffp_pkg::CREDIT_W-1:0] credits_left;
    logic                          cfg_ready;

    // packetizer state as this bench sees it
    int                         pq_size [QDEPTH];
    logic [cffp_pkg::TAG_W-1:0] pq_tag [QDEPTH];
    int                         pq_head;
    int                         pq_tail;
    int                         pq_count;
    int                         flit_pos;
    int                         credit_cnt;
    bit                         id_seen;
    logic [cffp_pkg::ID_W-1:0]  last_id;

    flit_res_t awaited_words[$];
    flit_res_t seen_want;
    dir_row_t  dir_rows[$];
    int        errors = 0;
    int        words_seen = 0;
    bit        idle_on = 1'b1;
    int        stall_left = 0;

    int phase_cfg [N_PHASES] = '{64, 0, 1, 63, -1, 32, 2, 4};
    int phase_pkt [N_PHASES] = '{20, 45, 25, 15, 25, 30, 35, 20};
    bit phase_idle [N_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 0};

    credit_flow_flit_packetizer_unit #(
        .QUEUE_DEPTH      (QDEPTH),
        .MAX_PACKET_FLITS (MAX_FLITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .packet_size    (packet_size),
        .packet_tag     (packet_tag),
        .credit_id      (credit_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .flit_valid     (flit_valid),
        .flit_kind      (flit_kind),
        .flit_seq       (flit_seq),
        .flit_tag       (flit_tag),
        .packet_dropped (packet_dropped),
        .credits_left   (credits_left),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .credit_init    (credit_init)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function automatic void reset_state();
        pq_head    = 0;
        pq_tail    = 0;
        pq_count   = 0;
        flit_pos   = 0;
        credit_cnt = cffp_pkg::CREDIT_RESET;
        id_seen    = 1'b0;
        last_id    = '0;
    endfunction

    // Advance the packetizer state by one input word and return its result word.
    function automatic flit_res_t packetize_word(input in_word_t w);
        flit_res_t r;
        int        sz;
        r = '{fv: 1'b0, kind: cffp_pkg::KIND_HEAD, seq: '0, tag: '0, dropped: 1'b0,
              credits: '0};
        case (w.mode)
            cffp_pkg::MODE_PACKET:
            begin
                // size zero becomes a single, oversize saturates
                sz = w.size;
                if (sz == 0)
                    sz = 1;
                if (sz > MAX_FLITS)
                    sz = MAX_FLITS;
                if (pq_count >= QDEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    pq_size[pq_tail] = sz;
                    pq_tag[pq_tail]  = w.tag;
                    pq_tail          = (pq_tail + 1) % QDEPTH;
                    pq_count++;
                end
            end
            cffp_pkg::MODE_CREDIT:
            begin
                // drop a repeated id; hold the counter at the ceiling
                if (!id_seen || last_id != w.id)
                    if (credit_cnt < int'(cffp_pkg::CREDIT_CEILING))
                        credit_cnt++;
                id_seen = 1'b1;
                last_id = w.id;
            end
            cffp_pkg::MODE_TICK:
            begin
                if (pq_count != 0 && credit_cnt != 0)
                begin
                    sz = pq_size[pq_head];
                    if (sz == 1)
                        r.kind = cffp_pkg::KIND_SINGLE;
                    else if (flit_pos == 0)
                        r.kind = cffp_pkg::KIND_HEAD;
                    else if (flit_pos == sz - 1)
                        r.kind = cffp_pkg::KIND_TAIL;
                    else
                        r.kind = cffp_pkg::KIND_BODY;
                    r.fv  = 1'b1;
                    r.seq = cffp_pkg::SEQ_W'(flit_pos);
                    r.tag = pq_tag[pq_head];
                    credit_cnt--;
                    if (flit_pos + 1 >= sz)
                    begin
                        flit_pos = 0;
                        pq_head  = (pq_head + 1) % QDEPTH;
                        pq_count--;
                    end
                    else
                        flit_pos++;
                end
            end
            default: ;
        endcase
        r.credits = cffp_pkg::CREDIT_W'(credit_cnt);
        return r;
    endfunction

    // Present one input word, hold it until accepted, then file its result word.
    task automatic push_word(input in_word_t w, input bit typed, input flit_res_t want);
        flit_res_t pred;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= w.mode;
        packet_size <= w.size;
        packet_tag  <= w.tag;
        credit_id   <= w.id;
        do
            @(posedge clk);
        while (in_stall);
        pred = packetize_word(w);
        awaited_words = {awaited_words, (typed ? want : pred)};
    endtask

    // Drain the block, then write the credit register.
    task automatic write_credit_init(input logic [cffp_pkg::CREDIT_W-1:0] value);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid   <= 1'b1;
        credit_init <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        credit_cnt = value;
    endtask

    // For a config row the credits field carries the register value.
    task automatic add_row(input row_kind_t kind, input logic [1:0] m,
                           input logic [cffp_pkg::SIZE_W-1:0] sz,
                           input logic [cffp_pkg::TAG_W-1:0] tg,
                           input logic [cffp_pkg::ID_W-1:0] id, input logic fv,
                           input logic [1:0] fk, input logic [cffp_pkg::SEQ_W-1:0] fs,
                           input logic [cffp_pkg::TAG_W-1:0] ft, input logic fd,
                           input logic [cffp_pkg::CREDIT_W-1:0] fc);
        dir_row_t r;
        r.kind = kind;
        r.w    = '{mode: m, size: sz, tag: tg, id: id};
        r.want = '{fv: fv, kind: fk, seq: fs, tag: ft, dropped: fd, credits: fc};
        dir_rows = {dir_rows, r};
    endtask

    // Random word, mostly well formed; unused fields still carry random bits.
    function automatic in_word_t rand_word(input int pkt_pct);
        in_word_t w;
        int       pick;
        int       sel;
        w.size = cffp_pkg::SIZE_W'($urandom_range(0, 127));
        w.tag  = cffp_pkg::TAG_W'($urandom);
        w.id   = cffp_pkg::ID_W'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 2)
            w.mode = MODE_SPARE;
        else if (pick < 2 + pkt_pct)
        begin
            w.mode = cffp_pkg::MODE_PACKET;
            sel    = $urandom_range(0, 9);
            case (sel)
                0: w.size = 7'd0;
                1: w.size = cffp_pkg::SIZE_W'($urandom_range(65, 127));
                2: w.size = 7'd64;
                3: ;
                default: w.size = cffp_pkg::SIZE_W'($urandom_range(1, 8));
            endcase
        end
        else if (pick < 27 + pkt_pct)
        begin
            w.mode = cffp_pkg::MODE_CREDIT;
            // repeat the last id now and then to hit the duplicate filter
            if (id_seen && $urandom_range(0, 3) == 0)
                w.id = last_id;
        end
        else
            w.mode = cffp_pkg::MODE_TICK;
        return w;
    endfunction

    // Output side: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // Compare every accepted result word with the oldest one awaited.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_words.size() == 0)
                report_mismatch($sformatf("result word %0d with nothing awaited", words_seen));
            else
            begin
                seen_want = awaited_words.pop_front();
                if (flit_valid !== seen_want.fv)
                    report_mismatch($sformatf("word %0d flit_valid got %0h want %0h",
                                              words_seen, flit_valid, seen_want.fv));
                if (flit_kind !== seen_want.kind)
                    report_mismatch($sformatf("word %0d flit_kind got %0h want %0h",
                                              words_seen, flit_kind, seen_want.kind));
                if (flit_seq !== seen_want.seq)
                    report_mismatch($sformatf("word %0d flit_seq got %0h want %0h",
                                              words_seen, flit_seq, seen_want.seq));
                if (flit_tag !== seen_want.tag)
                    report_mismatch($sformatf("word %0d flit_tag got %0h want %0h",
                                              words_seen, flit_tag, seen_want.tag));
                if (packet_dropped !== seen_want.dropped)
                    report_mismatch($sformatf("word %0d packet_dropped got %0h want %0h",
                                              words_seen, packet_dropped, seen_want.dropped));
                if (credits_left !== seen_want.credits)
                    report_mismatch($sformatf("word %0d credits_left got %0h want %0h",
                                              words_seen, credits_left, seen_want.credits));
            end
            words_seen++;
        end
    end

    initial
    begin
        in_word_t  w;
        flit_res_t none;
        int        cfg;
        none = '{fv: 1'b0, kind: cffp_pkg::KIND_HEAD, seq: '0, tag: '0, dropped: 1'b0,
                 credits: '0};
        reset_state();

        // Directed rows. Checked rows carry their result word typed in.
        // empty queue, then the unused mode with every payload bit set
        add_row(ROW_CHECKED, cffp_pkg::MODE_TICK, 7'd0, 16'h0000, 16'h0000,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd4);
        add_row(ROW_CHECKED, MODE_SPARE, 7'h7f, 16'hffff, 16'hffff,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd4);
        // fresh id counts, a repeat does not
        add_row(ROW_CHECKED, cffp_pkg::MODE_CREDIT, 7'd0, 16'h0000, 16'h0000,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd5);
        add_row(ROW_CHECKED, cffp_pkg::MODE_CREDIT, 7'd0, 16'h0000, 16'h0000,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd5);
        add_row(ROW_CHECKED, cffp_pkg::MODE_CREDIT, 7'd0, 16'h0000, 16'hffff,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd6);
        // size zero goes out as a single flit
        add_row(ROW_CHECKED, cffp_pkg::MODE_PACKET, 7'd0, 16'hffff, 16'h0000,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd6);
        add_row(ROW_CHECKED, cffp_pkg::MODE_TICK, 7'd0, 16'h0000, 16'h0000,
                1'b1, cffp_pkg::KIND_SINGLE, 6'd0, 16'hffff, 1'b0, 7'd5);
        // oversize packet saturates to the flit limit
        add_row(ROW_CHECKED, cffp_pkg::MODE_PACKET, 7'h7f, 16'h1234, 16'h0000,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd5);
        add_row(ROW_CHECKED, cffp_pkg::MODE_TICK, 7'd0, 16'h0000, 16'h0000,
                1'b1, cffp_pkg::KIND_HEAD, 6'd0, 16'h1234, 1'b0, 7'd4);
        add_row(ROW_CHECKED, cffp_pkg::MODE_TICK, 7'd0, 16'h0000, 16'h0000,
                1'b1, cffp_pkg::KIND_BODY, 6'd1, 16'h1234, 1'b0, 7'd3);
        // no credits: a tick sends nothing although packets wait
        add_row(ROW_CFG, cffp_pkg::MODE_TICK, 7'd0, 16'h0, 16'h0,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd0);
        add_row(ROW_CHECKED, cffp_pkg::MODE_TICK, 7'd0, 16'h0000, 16'h0000,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd0);
        add_row(ROW_WORD, cffp_pkg::MODE_PACKET, 7'd1, 16'h0000, 16'haaaa,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd0);
        add_row(ROW_WORD, cffp_pkg::MODE_PACKET, 7'd64, 16'h8000, 16'h5555,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd0);
        add_row(ROW_WORD, cffp_pkg::MODE_PACKET, 7'd2, 16'h5555, 16'h0000,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd0);
        // full counter: a fresh credit is not counted, its id is still kept
        add_row(ROW_CFG, cffp_pkg::MODE_TICK, 7'd0, 16'h0, 16'h0,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd64);
        add_row(ROW_CHECKED, cffp_pkg::MODE_CREDIT, 7'd0, 16'h0000, 16'h0001,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd64);
        add_row(ROW_CHECKED, cffp_pkg::MODE_TICK, 7'd0, 16'h0000, 16'h0000,
                1'b1, cffp_pkg::KIND_BODY, 6'd2, 16'h1234, 1'b0, 7'd63);
        add_row(ROW_CHECKED, cffp_pkg::MODE_CREDIT, 7'd0, 16'h0000, 16'h0001,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd63);
        add_row(ROW_CHECKED, cffp_pkg::MODE_CREDIT, 7'd0, 16'h0000, 16'h0002,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd64);
        add_row(ROW_WORD, cffp_pkg::MODE_TICK, 7'h55, 16'haaaa, 16'h5555,
                1'b0, cffp_pkg::KIND_HEAD, 6'd0, 16'h0, 1'b0, 7'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_credit_init(dir_rows[i].want.credits);
            else
                push_word(dir_rows[i].w, dir_rows[i].kind == ROW_CHECKED, dir_rows[i].want);
        end

        // Random phases: each reloads the credits at idle, then streams words.
        // The zero-credit phase leans on packets so the queue fills and drops.
        for (int p = 0; p < N_PHASES; p++)
        begin
            cfg = (phase_cfg[p] < 0) ? $urandom_range(0, 64) : phase_cfg[p];
            write_credit_init(cffp_pkg::CREDIT_W'(cfg));
            idle_on = phase_idle[p];
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                w = rand_word(phase_pkt[p]);
                push_word(w, 1'b0, none);
            end
        end

        // Drop valid, let every result word arrive, then idle before the verdict.
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
